// File: sv/tgsr_pkg.sv
// shared types and constants for the tile id to source rectangle unit
package tgsr_pkg;

	localparam int NUM_TILESETS_DEF = 4;
	localparam int TS_REGS          = 4;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 32;
	localparam int POS_W            = 12;
	localparam int COLS_W           = 13;
	localparam int TILE_W           = 9;
	localparam int GID_W            = 16;
	localparam int PROD_W           = GID_W + TILE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLUMNS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILESET_0   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TILESET_3   = 3'd6;

	localparam logic [COLS_W-1:0] MAP_COLS_MAX = 13'd4096;

	localparam logic [19:0] SCREEN_MAX = 20'hFFFFF;
	localparam logic [23:0] SRC_Y_MAX  = 24'hFFFFFF;

	// product slots of the shared multiplier
	localparam logic [1:0] TAG_SCREEN_X = 2'd0;
	localparam logic [1:0] TAG_SCREEN_Y = 2'd1;
	localparam logic [1:0] TAG_SOURCE_X = 2'd2;
	localparam logic [1:0] TAG_SOURCE_Y = 2'd3;

	typedef struct packed {
		logic [GID_W-1:0] gid;
		logic             map_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       tileset_index;
		logic [GID_W-1:0] tile_id;
		logic [19:0]      screen_x;
		logic [19:0]      screen_y;
		logic [15:0]      source_x;
		logic [23:0]      source_y;
	} out_item_t;

	typedef struct packed {
		logic [COLS_W-1:0] map_columns;
		logic [TILE_W-1:0] tile_width;
		logic [TILE_W-1:0] tile_height;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [GID_W-1:0] dividend;
		logic [GID_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [GID_W-1:0] quotient;
		logic [GID_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        tag;
		logic [GID_W-1:0]  a;
		logic [TILE_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        tag;
		logic [PROD_W-1:0] product;
	} mul_rsp_t;

endpackage

// File: sv/tgsr_if.sv
// valid/ready channels for tile ids in and source rectangles out
interface tgsr_in_if import tgsr_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tgsr_out_if import tgsr_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/tgsr_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
module tgsr_div import tgsr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [GID_W-1:0] quo_q;
	logic [GID_W-1:0] rem_q;
	logic [GID_W-1:0] dvs_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [GID_W:0]   shifted;
	logic [GID_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[GID_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(GID_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[GID_W-1:0] : shifted[GID_W-1:0];
			quo_q <= {quo_q[GID_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;
endmodule

// File: sv/tgsr_mul.sv
// shared 16x9 multiplier with a registered product and pass-through tag
module tgsr_mul import tgsr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);
	logic              valid_s1;
	logic [1:0]        tag_s1;
	logic [PROD_W-1:0] product_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1     <= req.tag;
		product_s1 <= PROD_W'(req.a) * PROD_W'(req.b);
	end

	assign rsp.valid   = valid_s1;
	assign rsp.tag     = tag_s1;
	assign rsp.product = product_s1;
endmodule

// File: sv/tgsr_seq.sv
// sequencer: map position, tileset pick, and the steps through divider and multiplier
module tgsr_seq import tgsr_pkg::*; #(
	parameter int NUM_TILESETS = NUM_TILESETS_DEF,
	localparam int NUM_SEARCH  = (NUM_TILESETS < TS_REGS) ? NUM_TILESETS : TS_REGS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic [NUM_SEARCH-1:0][31:0] ts_words,
	input  logic                        item_valid,
	input  in_item_t                    item,
	output logic                        item_ready,
	output logic                        push,
	output out_item_t                   result,
	input  logic                        push_ready,
	output div_req_t                    div_req,
	input  div_rsp_t                    div_rsp,
	output mul_req_t                    mul_req,
	input  mul_rsp_t                    mul_rsp
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEL  = 3'd1;
	localparam logic [2:0] ST_DIV1 = 3'd2;
	localparam logic [2:0] ST_DIV2 = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_MULW = 3'd5;
	localparam logic [2:0] ST_PUSH = 3'd6;

	logic [2:0]       state_q;
	logic [1:0]       k_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] cur_col_q;
	logic [POS_W-1:0] cur_row_q;
	logic [GID_W-1:0] gid_q;
	logic [GID_W-1:0] first_q;
	out_item_t        res_q;

	logic [POS_W-1:0]  base_col;
	logic [POS_W-1:0]  base_row;
	logic [COLS_W-1:0] cols_eff;
	logic              wrap;
	logic              found;
	logic [GID_W-1:0]  best_first;
	logic [GID_W-1:0]  best_img;
	logic [1:0]        best_idx;
	logic              go;
	logic              accept;

	assign accept     = item_valid && (state_q == ST_IDLE);
	assign item_ready = (state_q == ST_IDLE);
	assign push       = (state_q == ST_PUSH);
	assign result     = res_q;

	// position of this cell and the advance past it
	assign base_col = item.map_start ? '0 : col_q;
	assign base_row = item.map_start ? '0 : row_q;

	always_comb begin
		if (cfg.map_columns == '0) begin
			cols_eff = COLS_W'(1);
		end else if (cfg.map_columns > MAP_COLS_MAX) begin
			cols_eff = MAP_COLS_MAX;
		end else begin
			cols_eff = cfg.map_columns;
		end
	end

	assign wrap = ({1'b0, base_col} + COLS_W'(1)) >= cols_eff;

	// largest nonzero first id not above gid, lower index on a tie
	always_comb begin
		found      = 1'b0;
		best_first = '0;
		best_img   = '0;
		best_idx   = '0;
		for (int i = 0; i < NUM_SEARCH; i++) begin
			if (ts_words[i][15:0] != '0 && ts_words[i][15:0] <= gid_q &&
					ts_words[i][15:0] > best_first) begin
				found      = 1'b1;
				best_first = ts_words[i][15:0];
				best_img   = ts_words[i][31:16];
				best_idx   = 2'(i);
			end
		end
	end

	assign go = (gid_q != '0) && found && (cfg.tile_width != '0);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = best_img;
		div_req.divisor  = GID_W'(cfg.tile_width);
		unique case (state_q)
			ST_SEL: begin
				div_req.start = go;
			end
			ST_DIV1: begin
				// second pass: offset by tile columns
				div_req.start    = div_rsp.done && (div_rsp.quotient != '0);
				div_req.dividend = gid_q - first_q;
				div_req.divisor  = div_rsp.quotient;
			end
			default: ;
		endcase
	end

	always_comb begin
		mul_req.valid = (state_q == ST_MUL);
		mul_req.tag   = k_q;
		case (k_q)
			TAG_SCREEN_X: begin
				mul_req.a = GID_W'(cur_col_q);
				mul_req.b = cfg.tile_width;
			end
			TAG_SCREEN_Y: begin
				mul_req.a = GID_W'(cur_row_q);
				mul_req.b = cfg.tile_height;
			end
			TAG_SOURCE_X: begin
				mul_req.a = div_rsp.remainder;
				mul_req.b = cfg.tile_width;
			end
			default: begin
				mul_req.a = div_rsp.quotient;
				mul_req.b = cfg.tile_height;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_SEL;
						if (wrap) begin
							col_q <= '0;
							row_q <= base_row + POS_W'(1);
						end else begin
							col_q <= base_col + POS_W'(1);
							row_q <= base_row;
						end
					end
				end
				ST_SEL: begin
					state_q <= go ? ST_DIV1 : ST_IDLE;
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						state_q <= (div_rsp.quotient != '0) ? ST_DIV2 : ST_IDLE;
					end
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL;
						k_q     <= '0;
					end
				end
				ST_MUL: begin
					k_q <= k_q + 2'd1;
					if (k_q == TAG_SOURCE_Y) begin
						state_q <= ST_MULW;
					end
				end
				ST_MULW: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gid_q     <= item.gid;
			cur_col_q <= base_col;
			cur_row_q <= base_row;
		end
		if (state_q == ST_SEL) begin
			first_q             <= best_first;
			res_q.tileset_index <= best_idx;
			res_q.tile_id       <= gid_q;
		end
		if (mul_rsp.valid) begin
			case (mul_rsp.tag)
				TAG_SCREEN_X: begin
					res_q.screen_x <= (mul_rsp.product > PROD_W'(SCREEN_MAX)) ?
						SCREEN_MAX : mul_rsp.product[19:0];
				end
				TAG_SCREEN_Y: begin
					res_q.screen_y <= (mul_rsp.product > PROD_W'(SCREEN_MAX)) ?
						SCREEN_MAX : mul_rsp.product[19:0];
				end
				TAG_SOURCE_X: begin
					res_q.source_x <= mul_rsp.product[15:0];
				end
				default: begin
					res_q.source_y <= (mul_rsp.product > PROD_W'(SRC_Y_MAX)) ?
						SRC_Y_MAX : mul_rsp.product[23:0];
				end
			endcase
		end
	end
endmodule

// File: sv/tile_gid_to_source_rect_unit.sv
// tile id to tileset source rectangle: top level with config registers and output register
//
// Takes map tile ids in row-major order and returns, for each nonempty id that
// falls in a usable tileset, the tileset index, the id, the screen position of
// the cell and the pixel position of the tile inside the tileset image. One
// id is handled at a time: tile_ch.ready is high only while the unit is idle.
// An empty id, an id below every tileset, a zero tile width or an image narrower
// than one tile gives no result; a result may wait for the output register to drain.
// Each result takes two 16-step passes through the one shared radix-2 divider
// (image width by tile width, then tile offset by tile columns) and four passes
// through the one shared multiplier. The output register lets the next id be
// taken while a result still waits. The user must write configuration through
// cfg_we, cfg_index and cfg_data only while the unit is idle; the block itself
// does not enforce this. Writes to unknown indexes are ignored.
module tile_gid_to_source_rect_unit import tgsr_pkg::*; #(
	parameter int NUM_TILESETS = NUM_TILESETS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tgsr_in_if.sink               tile_ch,
	tgsr_out_if.source            rect_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int NUM_SEARCH = (NUM_TILESETS < TS_REGS) ? NUM_TILESETS : TS_REGS;

	cfg_t                        cfg_q;
	logic [NUM_SEARCH-1:0][31:0] ts_q;
	logic                        out_valid_q;
	out_item_t                   out_data_q;
	logic                        push;
	logic                        push_ready;
	out_item_t                   result;
	div_req_t                    div_req;
	div_rsp_t                    div_rsp;
	mul_req_t                    mul_req;
	mul_rsp_t                    mul_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_columns <= COLS_W'(1);
			cfg_q.tile_width  <= TILE_W'(32);
			cfg_q.tile_height <= TILE_W'(32);
			ts_q              <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				CFG_MAP_COLUMNS: cfg_q.map_columns <= cfg_data[COLS_W-1:0];
				CFG_TILE_WIDTH:  cfg_q.tile_width  <= cfg_data[TILE_W-1:0];
				CFG_TILE_HEIGHT: cfg_q.tile_height <= cfg_data[TILE_W-1:0];
				[CFG_TILESET_0:CFG_TILESET_3]: begin
					// words past the searched tilesets have no storage
					for (int i = 0; i < NUM_SEARCH; i++) begin
						if (cfg_index == CFG_IDX_W'(CFG_TILESET_0 + i)) begin
							ts_q[i] <= cfg_data;
						end
					end
				end
				default: ;
			endcase
		end
	end

	tgsr_seq #(
		.NUM_TILESETS(NUM_TILESETS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.ts_words   (ts_q),
		.item_valid (tile_ch.valid),
		.item       (tile_ch.data),
		.item_ready (tile_ch.ready),
		.push       (push),
		.result     (result),
		.push_ready (push_ready),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.mul_req    (mul_req),
		.mul_rsp    (mul_rsp)
	);

	tgsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tgsr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign push_ready = !out_valid_q || rect_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push && push_ready) begin
			out_valid_q <= 1'b1;
		end else if (rect_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			out_data_q <= result;
		end
	end

	assign rect_ch.valid = out_valid_q;
	assign rect_ch.data  = out_data_q;
endmodule
